// File: src/vpft_pkg.sv
// ----------------------------------------------------------------------------
// vpft_pkg
// shared widths, the pipeline word of the cordic chain and the elaboration
// time functions for the arctangent table and the inverse cordic gain
// ----------------------------------------------------------------------------
package vpft_pkg;

    localparam int IN_W             = 32;
    localparam int GUARD_BITS       = 16;
    localparam int DW               = IN_W + GUARD_BITS + 3;
    localparam int ZW               = 64;
    localparam int ANGLE_FRAC       = 60;
    localparam int GAIN_W           = 30;
    localparam int RES_W            = DW + 2 - GUARD_BITS;
    localparam int US_LAT           = 5;
    localparam int HEAD_W           = 19;
    localparam int SPEED_W          = 31;
    localparam int CORDIC_STEPS_DEF = 20;
    localparam int FRAC_BITS_DEF    = 16;

    typedef struct packed {
        logic                   zero;
        logic signed [IN_W-1:0] acc_x;
        logic signed [IN_W-1:0] acc_y;
        logic signed [DW-1:0]   x;
        logic signed [DW-1:0]   y;
        logic signed [DW-1:0]   u;
        logic signed [DW-1:0]   w;
        logic signed [ZW-1:0]   z;
    } vpft_cordic_t;

    // restoring division, elaboration only
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[62:0], num[b]};
            if (r >= den)
            begin
                r    = r - den;
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    // atan(1/n) in q60 by the truncated gregory series
    function automatic logic signed [63:0] atan_recip(input logic [63:0] n);
        logic [63:0]        p;
        logic signed [63:0] sum;
        logic signed [63:0] term;
        p   = udiv64(64'd1 << ANGLE_FRAC, n);
        sum = '0;
        for (int k = 0; k < 64; k++)
        begin
            if (p != 64'd0)
            begin
                term = signed'(udiv64(p, 64'(2 * k + 1)));
                if (k % 2 == 1)
                    sum = sum - term;
                else
                    sum = sum + term;
                p = udiv64(udiv64(p, n), n);
            end
        end
        return sum;
    endfunction

    function automatic logic signed [63:0] atan_q60(input int unsigned i);
        logic signed [63:0] a;
        if (i == 0)
            a = atan_recip(64'd2) + atan_recip(64'd3);
        else if (i >= ANGLE_FRAC)
            a = '0;
        else
            a = atan_recip(64'd1 << i);
        return a;
    endfunction

    // largest q30 g with floor(g*g / 2^30) * p <= 2^60, p the q30 product of (1 + 4^-i)
    function automatic logic [63:0] inv_gain_q30(input int steps);
        logic [63:0] p;
        logic [63:0] g;
        logic [63:0] c;
        p = 64'd1 << GAIN_W;
        g = '0;
        for (int i = 0; i < steps; i++)
        begin
            if (2 * i < 64)
                p = p + (p >> (2 * i));
        end
        for (int b = GAIN_W - 1; b >= 0; b--)
        begin
            c = g | (64'd1 << b);
            if ((((c * c) >> GAIN_W) * p) <= (64'd1 << (2 * GAIN_W)))
                g = c;
        end
        return g;
    endfunction

    function automatic logic signed [DW-1:0] scale_in(input logic signed [IN_W-1:0] v);
        return {{(DW - IN_W - GUARD_BITS){v[IN_W-1]}}, v, {GUARD_BITS{1'b0}}};
    endfunction

    localparam logic signed [ZW-1:0] PI_HALF = 2 * atan_q60(0);

endpackage

// File: src/vpft_prerot.sv
// ----------------------------------------------------------------------------
// vpft_prerot
// input register: guard scaling, quarter turn of both vectors into the right
// half plane and the zero velocity flag
// ----------------------------------------------------------------------------
module vpft_prerot
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic signed [31:0]              vel_x,
    input  logic signed [31:0]              vel_y,
    input  logic signed [31:0]              acc_x,
    input  logic signed [31:0]              acc_y,
    output logic                            out_valid,
    output vpft_pkg::vpft_cordic_t          out_data
);
    import vpft_pkg::*;

    logic                 valid_reg;
    vpft_cordic_t         data_reg;
    vpft_cordic_t         data_next;
    logic signed [DW-1:0] x0;
    logic signed [DW-1:0] y0;
    logic signed [DW-1:0] u0;
    logic signed [DW-1:0] w0;

    always_comb
    begin
        x0              = scale_in(vel_x);
        y0              = scale_in(vel_y);
        u0              = scale_in(acc_x);
        w0              = scale_in(acc_y);
        data_next.zero  = (vel_x == '0) && (vel_y == '0);
        data_next.acc_x = acc_x;
        data_next.acc_y = acc_y;
        data_next.x     = x0;
        data_next.y     = y0;
        data_next.u     = u0;
        data_next.w     = w0;
        data_next.z     = '0;
        // left half plane: quarter turn towards the x axis
        if (vel_x[IN_W-1])
        begin
            if (!vel_y[IN_W-1])
            begin
                data_next.x = y0;
                data_next.y = -x0;
                data_next.u = w0;
                data_next.w = -u0;
                data_next.z = PI_HALF;
            end
            else
            begin
                data_next.x = -y0;
                data_next.y = x0;
                data_next.u = -w0;
                data_next.w = u0;
                data_next.z = -PI_HALF;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/vpft_cordic_stage.sv
// ----------------------------------------------------------------------------
// vpft_cordic_stage
// one registered micro-rotation: vectoring on the velocity, the same turn
// applied to the acceleration
// ----------------------------------------------------------------------------
module vpft_cordic_stage
#(
    parameter int unsigned STAGE = 0
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    input  vpft_pkg::vpft_cordic_t in_data,
    output logic                   out_valid,
    output vpft_pkg::vpft_cordic_t out_data
);
    import vpft_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_q60(STAGE);

    logic                 valid_reg;
    vpft_cordic_t         data_reg;
    vpft_cordic_t         data_next;
    logic signed [DW-1:0] xs;
    logic signed [DW-1:0] ys;
    logic signed [DW-1:0] us;
    logic signed [DW-1:0] ws;

    always_comb
    begin
        xs        = in_data.x >>> STAGE;
        ys        = in_data.y >>> STAGE;
        us        = in_data.u >>> STAGE;
        ws        = in_data.w >>> STAGE;
        data_next = in_data;
        // y at or above zero: clockwise step
        if (!in_data.y[DW-1])
        begin
            data_next.x = in_data.x + ys;
            data_next.y = in_data.y - xs;
            data_next.u = in_data.u + ws;
            data_next.w = in_data.w - us;
            data_next.z = in_data.z + ATAN;
        end
        else
        begin
            data_next.x = in_data.x - ys;
            data_next.y = in_data.y + xs;
            data_next.u = in_data.u - ws;
            data_next.w = in_data.w + us;
            data_next.z = in_data.z - ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: src/vpft_unscale.sv
// ----------------------------------------------------------------------------
// vpft_unscale
// gain removal for one lane: magnitude times the q30 inverse gain in two
// partial products, rounding from guard scale to q16.16, sign restored
// ----------------------------------------------------------------------------
module vpft_unscale
#(
    parameter logic [vpft_pkg::GAIN_W-1:0] INV_GAIN =
        vpft_pkg::GAIN_W'(vpft_pkg::inv_gain_q30(vpft_pkg::CORDIC_STEPS_DEF))
)
(
    input  logic                              clk,
    input  logic signed [vpft_pkg::DW-1:0]    value,
    output logic signed [vpft_pkg::RES_W-1:0] result
);
    import vpft_pkg::*;

    localparam int HI_W = DW - IN_W;
    localparam int LP_W = IN_W + GAIN_W;
    localparam int HP_W = HI_W + GAIN_W;
    localparam int T_W  = DW + 1;
    localparam int M_W  = T_W - GUARD_BITS;
    localparam int SH   = IN_W - GAIN_W;

    logic [DW-1:0]           mag_reg;
    logic [DW-1:0]           mag_next;
    logic                    neg1_reg;
    logic [LP_W-1:0]         lo_prod;
    logic [IN_W-1:0]         lo_part2_reg;
    logic [HI_W-1:0]         hi2_reg;
    logic                    neg2_reg;
    logic [HP_W-1:0]         hi_prod_next;
    logic [HP_W-1:0]         hi_prod3_reg;
    logic [IN_W-1:0]         lo_part3_reg;
    logic                    neg3_reg;
    logic [T_W-1:0]          t_sum;
    logic [T_W-1:0]          t_rnd;
    logic [M_W-1:0]          mag_r4_reg;
    logic                    neg4_reg;
    logic signed [RES_W-1:0] res_mag;
    logic signed [RES_W-1:0] result_next;
    logic signed [RES_W-1:0] result_reg;

    always_comb
    begin
        mag_next     = value[DW-1] ? DW'(-value) : DW'(value);
        lo_prod      = LP_W'(mag_reg[IN_W-1:0]) * LP_W'(INV_GAIN);
        hi_prod_next = HP_W'(hi2_reg) * HP_W'(INV_GAIN);
        t_sum        = (T_W'(hi_prod3_reg) << SH) + T_W'(lo_part3_reg);
        t_rnd        = t_sum + (T_W'(1) << (GUARD_BITS - 1));
        res_mag      = signed'({1'b0, mag_r4_reg});
        result_next  = neg4_reg ? -res_mag : res_mag;
    end

    always_ff @(posedge clk)
    begin
        mag_reg      <= mag_next;
        neg1_reg     <= value[DW-1];
        lo_part2_reg <= lo_prod[LP_W-1:GAIN_W];
        hi2_reg      <= mag_reg[DW-1:IN_W];
        neg2_reg     <= neg1_reg;
        hi_prod3_reg <= hi_prod_next;
        lo_part3_reg <= lo_part2_reg;
        neg3_reg     <= neg2_reg;
        mag_r4_reg   <= t_rnd[T_W-1:GUARD_BITS];
        neg4_reg     <= neg3_reg;
        result_reg   <= result_next;
    end

    assign result = result_reg;

endmodule

// File: src/velocity_polar_frame_transform_top.sv
// ----------------------------------------------------------------------------
// velocity_polar_frame_transform_top
// speed, heading and path-frame acceleration of one path sample per cycle
// ----------------------------------------------------------------------------
// A sample is taken on every cycle with start high; busy never rises. Each
// sample gives one result beat, marked by done for one cycle, after it has
// passed one input register, one register per micro-rotation, five stages of
// gain removal (two partial products per lane) and the output register.
// Results leave in input order and cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module velocity_polar_frame_transform_top
#(
    parameter int CORDIC_STEPS = vpft_pkg::CORDIC_STEPS_DEF,
    parameter int FRAC_BITS    = vpft_pkg::FRAC_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [vpft_pkg::IN_W-1:0]    vel_x,
    input  logic signed [vpft_pkg::IN_W-1:0]    vel_y,
    input  logic signed [vpft_pkg::IN_W-1:0]    acc_x,
    input  logic signed [vpft_pkg::IN_W-1:0]    acc_y,
    output logic                                busy,
    output logic                                done,
    output logic        [vpft_pkg::SPEED_W-1:0] speed,
    output logic signed [vpft_pkg::HEAD_W-1:0]  heading,
    output logic signed [vpft_pkg::IN_W-1:0]    acc_tangential,
    output logic signed [vpft_pkg::IN_W-1:0]    acc_normal
);
    import vpft_pkg::*;

    localparam int HSH = ANGLE_FRAC - FRAC_BITS;
    localparam int HRW = ZW - HSH;
    localparam logic [GAIN_W-1:0]          INV_GAIN = GAIN_W'(inv_gain_q30(CORDIC_STEPS));
    localparam logic signed [RES_W-1:0]    POS_MAX  = RES_W'((64'sd1 <<< (IN_W - 1)) - 1);
    localparam logic signed [RES_W-1:0]    NEG_MIN  = -POS_MAX - 1;
    localparam logic signed [ZW-1:0]       HEAD_MAX = (64'sd1 <<< (HEAD_W - 1)) - 1;
    localparam logic signed [ZW-1:0]       HEAD_MIN = -HEAD_MAX - 1;

    typedef struct packed {
        logic                   zero;
        logic signed [IN_W-1:0] acc_x;
        logic signed [IN_W-1:0] acc_y;
        logic signed [HRW-1:0]  head;
    } side_t;

    logic         stage_valid [0:CORDIC_STEPS];
    vpft_cordic_t stage_data  [0:CORDIC_STEPS];

    logic                   sb_valid_reg [0:US_LAT-1];
    side_t                  sb_reg       [0:US_LAT-1];
    side_t                  sb_next;
    logic signed [ZW-1:0]   head_sum;

    logic signed [RES_W-1:0] speed_res;
    logic signed [RES_W-1:0] at_res;
    logic signed [RES_W-1:0] an_res;
    logic signed [ZW-1:0]    head_ext;

    logic                     done_reg;
    logic [SPEED_W-1:0]       speed_reg;
    logic [SPEED_W-1:0]       speed_next;
    logic signed [HEAD_W-1:0] heading_reg;
    logic signed [HEAD_W-1:0] heading_next;
    logic signed [IN_W-1:0]   at_reg;
    logic signed [IN_W-1:0]   at_next;
    logic signed [IN_W-1:0]   an_reg;
    logic signed [IN_W-1:0]   an_next;

    assign busy = 1'b0;

    vpft_prerot u_prerot
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (start && !busy),
        .vel_x     (vel_x),
        .vel_y     (vel_y),
        .acc_x     (acc_x),
        .acc_y     (acc_y),
        .out_valid (stage_valid[0]),
        .out_data  (stage_data[0])
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        vpft_cordic_stage #(.STAGE(i)) u_stage
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stage_valid[i]),
            .in_data   (stage_data[i]),
            .out_valid (stage_valid[i+1]),
            .out_data  (stage_data[i+1])
        );
    end

    vpft_unscale #(.INV_GAIN(INV_GAIN)) u_unscale_speed
    (
        .clk    (clk),
        .value  (stage_data[CORDIC_STEPS].x),
        .result (speed_res)
    );

    vpft_unscale #(.INV_GAIN(INV_GAIN)) u_unscale_tan
    (
        .clk    (clk),
        .value  (stage_data[CORDIC_STEPS].u),
        .result (at_res)
    );

    vpft_unscale #(.INV_GAIN(INV_GAIN)) u_unscale_norm
    (
        .clk    (clk),
        .value  (stage_data[CORDIC_STEPS].w),
        .result (an_res)
    );

    // heading rounded half up, carried alongside gain removal
    always_comb
    begin
        head_sum      = stage_data[CORDIC_STEPS].z + (ZW'(1) <<< (HSH - 1));
        sb_next.zero  = stage_data[CORDIC_STEPS].zero;
        sb_next.acc_x = stage_data[CORDIC_STEPS].acc_x;
        sb_next.acc_y = stage_data[CORDIC_STEPS].acc_y;
        sb_next.head  = signed'(head_sum[ZW-1:HSH]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < US_LAT; k++)
                sb_valid_reg[k] <= 1'b0;
        end
        else
        begin
            sb_valid_reg[0] <= stage_valid[CORDIC_STEPS];
            for (int k = 1; k < US_LAT; k++)
                sb_valid_reg[k] <= sb_valid_reg[k-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sb_reg[0] <= sb_next;
        for (int k = 1; k < US_LAT; k++)
            sb_reg[k] <= sb_reg[k-1];
    end

    // saturation and zero velocity bypass
    always_comb
    begin
        head_ext = ZW'(sb_reg[US_LAT-1].head);

        if (speed_res[RES_W-1])
            speed_next = '0;
        else if (speed_res > POS_MAX)
            speed_next = '1;
        else
            speed_next = speed_res[SPEED_W-1:0];

        if (head_ext > HEAD_MAX)
            heading_next = HEAD_MAX[HEAD_W-1:0];
        else if (head_ext < HEAD_MIN)
            heading_next = HEAD_MIN[HEAD_W-1:0];
        else
            heading_next = head_ext[HEAD_W-1:0];

        if (at_res > POS_MAX)
            at_next = POS_MAX[IN_W-1:0];
        else if (at_res < NEG_MIN)
            at_next = NEG_MIN[IN_W-1:0];
        else
            at_next = at_res[IN_W-1:0];

        if (an_res > POS_MAX)
            an_next = POS_MAX[IN_W-1:0];
        else if (an_res < NEG_MIN)
            an_next = NEG_MIN[IN_W-1:0];
        else
            an_next = an_res[IN_W-1:0];

        if (sb_reg[US_LAT-1].zero)
        begin
            speed_next   = '0;
            heading_next = '0;
            at_next      = sb_reg[US_LAT-1].acc_x;
            an_next      = sb_reg[US_LAT-1].acc_y;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sb_valid_reg[US_LAT-1];
    end

    always_ff @(posedge clk)
    begin
        speed_reg   <= speed_next;
        heading_reg <= heading_next;
        at_reg      <= at_next;
        an_reg      <= an_next;
    end

    assign done           = done_reg;
    assign speed          = speed_reg;
    assign heading        = heading_reg;
    assign acc_tangential = at_reg;
    assign acc_normal     = an_reg;

endmodule

// File: sim/velocity_polar_frame_transform_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// velocity_polar_frame_transform_top_tb
// Drives path samples into the polar frame transform and works out the
// expected speed, heading and path-frame acceleration of each one with a
// bit-exact fixed-point CORDIC model of its own. Each result beat is checked
// field by field against the oldest expectation.
// ----------------------------------------------------------------------------
module velocity_polar_frame_transform_top_tb;
    import vpft_pkg::*;

    localparam int     STEPS       = CORDIC_STEPS_DEF;
    localparam int     FRAC        = FRAC_BITS_DEF;
    localparam int     PIPE_LAT    = STEPS + 7;
    localparam int     IDLE_LIMIT  = 2000;
    localparam int     PRINT_LIMIT = 50;
    localparam longint GUARD_SCALE = longint'(1) <<< GUARD_BITS;
    localparam longint SPEED_MAX   = (longint'(1) <<< SPEED_W) - 1;
    localparam longint WORD_MAX    = (longint'(1) <<< (IN_W - 1)) - 1;
    localparam longint WORD_MIN    = -(longint'(1) <<< (IN_W - 1));
    localparam longint HEAD_MAX    = (longint'(1) <<< (HEAD_W - 1)) - 1;
    localparam longint HEAD_MIN    = -(longint'(1) <<< (HEAD_W - 1));

    typedef struct {
        logic signed [IN_W-1:0] vel_x;
        logic signed [IN_W-1:0] vel_y;
        logic signed [IN_W-1:0] acc_x;
        logic signed [IN_W-1:0] acc_y;
    } path_sample_t;

    typedef struct {
        logic        [SPEED_W-1:0] speed;
        logic signed [HEAD_W-1:0]  heading;
        logic signed [IN_W-1:0]    acc_tangential;
        logic signed [IN_W-1:0]    acc_normal;
    } frame_result_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic signed [IN_W-1:0]    vel_x;
    logic signed [IN_W-1:0]    vel_y;
    logic signed [IN_W-1:0]    acc_x;
    logic signed [IN_W-1:0]    acc_y;
    logic                      busy;
    logic                      done;
    logic        [SPEED_W-1:0] speed;
    logic signed [HEAD_W-1:0]  heading;
    logic signed [IN_W-1:0]    acc_tangential;
    logic signed [IN_W-1:0]    acc_normal;

    frame_result_t   frame_results_due[$];
    longint          atan_q60_tab[STEPS];
    longint          half_pi_q60;
    longint unsigned inv_gain;
    int              mismatch_count = 0;
    bit              gaps_on;

    velocity_polar_frame_transform_top u_dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .vel_x          (vel_x),
        .vel_y          (vel_y),
        .acc_x          (acc_x),
        .acc_y          (acc_y),
        .busy           (busy),
        .done           (done),
        .speed          (speed),
        .heading        (heading),
        .acc_tangential (acc_tangential),
        .acc_normal     (acc_normal)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // atan(1/n) in q60, gregory series truncated per term
    function automatic longint atan_of_recip(input longint unsigned n);
        longint unsigned p;
        longint unsigned k;
        longint          sum;
        p   = (64'd1 << ANGLE_FRAC) / n;
        sum = 0;
        for (k = 0; p != 0; k++)
        begin
            if (k[0])
                sum -= longint'(p / (2 * k + 1));
            else
                sum += longint'(p / (2 * k + 1));
            p = (p / n) / n;
        end
        return sum;
    endfunction

    // times the inverse gain, then rounded half away from zero to q16.16
    function automatic longint remove_gain(input longint a);
        longint unsigned mag;
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned prod;
        longint unsigned q;
        mag  = (a < 0) ? -a : a;
        hi   = mag >> 32;
        lo   = mag & 64'hFFFF_FFFF;
        prod = hi * inv_gain * 4 + ((lo * inv_gain) >> GAIN_W);
        q    = (prod + (64'd1 << (GUARD_BITS - 1))) >> GUARD_BITS;
        return (a < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint clamp(input longint v, input longint lo, input longint hi);
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    function automatic frame_result_t polar_frame_of(input path_sample_t s);
        frame_result_t r;
        longint        x;
        longint        y;
        longint        u;
        longint        w;
        longint        z;
        longint        t;
        longint        xs;
        longint        ys;
        longint        us;
        longint        ws;
        longint        hd;
        if (s.vel_x == 0 && s.vel_y == 0)
        begin
            r.speed          = '0;
            r.heading        = '0;
            r.acc_tangential = s.acc_x;
            r.acc_normal     = s.acc_y;
            return r;
        end
        x = longint'(s.vel_x) * GUARD_SCALE;
        y = longint'(s.vel_y) * GUARD_SCALE;
        u = longint'(s.acc_x) * GUARD_SCALE;
        w = longint'(s.acc_y) * GUARD_SCALE;
        z = 0;
        // left half plane: quarter turn first
        if (x < 0)
        begin
            if (y >= 0)
            begin
                t = x; x = y;  y = -t;
                t = u; u = w;  w = -t;
                z = half_pi_q60;
            end
            else
            begin
                t = x; x = -y; y = t;
                t = u; u = -w; w = t;
                z = -half_pi_q60;
            end
        end
        for (int i = 0; i < STEPS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            us = u >>> i;
            ws = w >>> i;
            if (y >= 0)
            begin
                x += ys; y -= xs;
                u += ws; w -= us;
                z += atan_q60_tab[i];
            end
            else
            begin
                x -= ys; y += xs;
                u -= ws; w += us;
                z -= atan_q60_tab[i];
            end
        end
        hd = (z + (longint'(1) <<< (ANGLE_FRAC - 1 - FRAC))) >>> (ANGLE_FRAC - FRAC);
        t  = clamp(remove_gain(x), 0, SPEED_MAX);
        r.speed          = t[SPEED_W-1:0];
        t  = clamp(hd, HEAD_MIN, HEAD_MAX);
        r.heading        = t[HEAD_W-1:0];
        t  = clamp(remove_gain(u), WORD_MIN, WORD_MAX);
        r.acc_tangential = t[IN_W-1:0];
        t  = clamp(remove_gain(w), WORD_MIN, WORD_MAX);
        r.acc_normal     = t[IN_W-1:0];
        return r;
    endfunction

    function automatic path_sample_t sample_of(input logic signed [IN_W-1:0] vx,
                                               input logic signed [IN_W-1:0] vy,
                                               input logic signed [IN_W-1:0] ax,
                                               input logic signed [IN_W-1:0] ay);
        path_sample_t s;
        s.vel_x = vx;
        s.vel_y = vy;
        s.acc_x = ax;
        s.acc_y = ay;
        return s;
    endfunction

    function automatic logic signed [IN_W-1:0] pick_word();
        logic signed [IN_W-1:0] v;
        case ($urandom_range(0, 7))
            0: v = $urandom_range(0, 131071) - 65536;
            1:
            begin
                v = $urandom;
                v = v >>> 8;
            end
            2:
            begin
                case ($urandom_range(0, 4))
                    0:       v = '0;
                    1:       v = {1'b0, {(IN_W - 1){1'b1}}};
                    2:       v = {1'b1, {(IN_W - 1){1'b0}}};
                    3:       v = 1;
                    default: v = '1;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    function automatic path_sample_t random_sample();
        path_sample_t s;
        s = sample_of(pick_word(), pick_word(), pick_word(), pick_word());
        if ($urandom_range(0, 29) == 0)
        begin
            s.vel_x = '0;
            s.vel_y = '0;
        end
        return s;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic issue_sample(input path_sample_t s);
        int gap;
        @(negedge clk);
        vel_x = s.vel_x;
        vel_y = s.vel_y;
        acc_x = s.acc_x;
        acc_y = s.acc_y;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        frame_results_due.push_back(polar_frame_of(s));
        gap = gaps_on ? $urandom_range(0, 5) : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (frame_results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_axes_and_quadrants();
        issue_sample(sample_of(0, 0, 32'sh7FFF_FFFF, 32'sh8000_0000));
        issue_sample(sample_of(0, 0, -1, 1));
        issue_sample(sample_of(65536, 0, 65536, 65536));
        issue_sample(sample_of(-65536, 0, 65536, -65536));
        issue_sample(sample_of(0, 65536, 65536, 0));
        issue_sample(sample_of(0, -65536, 0, 65536));
        issue_sample(sample_of(-65536, -1, 12345, -54321));
        issue_sample(sample_of(65536, 65536, 65536, 0));
        issue_sample(sample_of(-65536, 65536, 0, 65536));
        issue_sample(sample_of(-65536, -65536, -65536, 0));
        issue_sample(sample_of(65536, -65536, 0, -65536));
        issue_sample(sample_of(1, 0, 1, -1));
        issue_sample(sample_of(-1, 0, -1, 1));
    endtask

    task automatic test_field_extremes();
        logic signed [IN_W-1:0] w_max;
        logic signed [IN_W-1:0] w_min;
        w_max = {1'b0, {(IN_W - 1){1'b1}}};
        w_min = {1'b1, {(IN_W - 1){1'b0}}};
        issue_sample(sample_of(w_max, w_max, w_max, w_max));
        issue_sample(sample_of(w_min, w_min, w_min, w_min));
        issue_sample(sample_of(w_min, 0, w_max, w_min));
        issue_sample(sample_of(w_max, w_min, w_min, w_max));
        issue_sample(sample_of(0, w_min, w_max, w_max));
        issue_sample(sample_of(w_min, w_max, w_min, w_min));
        issue_sample(sample_of(w_max, 0, w_min, w_max));
        issue_sample(sample_of(-1, -1, w_max, w_min));
    endtask

    task automatic test_pause_until_drained();
        for (int round = 0; round < 3; round++)
        begin
            for (int n = 0; n < 40; n++)
                issue_sample(random_sample());
            wait_drained();
        end
    endtask

    task automatic test_back_to_back_stream();
        gaps_on = 1'b0;
        for (int n = 0; n < 150; n++)
            issue_sample(random_sample());
        gaps_on = 1'b1;
    endtask

    task automatic test_random_samples();
        for (int n = 0; n < 1360; n++)
        begin
            if (n % 64 == 0)
                gaps_on = ($urandom_range(0, 3) != 0);
            issue_sample(random_sample());
        end
        gaps_on = 1'b1;
    endtask

    always @(posedge clk)
    begin
        frame_result_t want;
        if (rst_n && done)
        begin
            if (frame_results_due.size() == 0)
                report_mismatch($sformatf("result beat with nothing due: speed %0d heading %0d",
                                          speed, heading));
            else
            begin
                want = frame_results_due.pop_front();
                if (speed !== want.speed)
                    report_mismatch($sformatf("speed got %0d want %0d", speed, want.speed));
                if (heading !== want.heading)
                    report_mismatch($sformatf("heading got %0d want %0d",
                                              heading, want.heading));
                if (acc_tangential !== want.acc_tangential)
                    report_mismatch($sformatf("acc_tangential got %0d want %0d",
                                              acc_tangential, want.acc_tangential));
                if (acc_normal !== want.acc_normal)
                    report_mismatch($sformatf("acc_normal got %0d want %0d",
                                              acc_normal, want.acc_normal));
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || done)
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        longint unsigned prod_gain;
        longint unsigned trial;
        rst_n   = 1'b0;
        start   = 1'b0;
        vel_x   = '0;
        vel_y   = '0;
        acc_x   = '0;
        acc_y   = '0;
        gaps_on = 1'b1;

        // arctangent table and inverse gain of the micro-rotation chain
        for (int i = 0; i < STEPS; i++)
            atan_q60_tab[i] = (i == 0) ? atan_of_recip(2) + atan_of_recip(3)
                                       : atan_of_recip(64'd1 << i);
        half_pi_q60 = 2 * atan_q60_tab[0];
        prod_gain   = 64'd1 << GAIN_W;
        for (int i = 0; i < STEPS; i++)
            prod_gain += prod_gain >> (2 * i);
        inv_gain = 0;
        for (int b = GAIN_W - 1; b >= 0; b--)
        begin
            trial = inv_gain | (64'd1 << b);
            if (((trial * trial) >> GAIN_W) * prod_gain <= (64'd1 << (2 * GAIN_W)))
                inv_gain = trial;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_axes_and_quadrants();
        test_field_extremes();
        test_pause_until_drained();
        test_back_to_back_stream();
        test_random_samples();

        wait_drained();
        repeat (PIPE_LAT + 5) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: filelist.f
src/vpft_pkg.sv
src/vpft_prerot.sv
src/vpft_cordic_stage.sv
src/vpft_unscale.sv
src/velocity_polar_frame_transform_top.sv
sim/velocity_polar_frame_transform_top_tb.sv
